### rtl/archive_magic_classifier_macros.svh
// Assertion helpers shared by the classifier RTL.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef ARCHIVE_MAGIC_CLASSIFIER_MACROS_SVH
`define ARCHIVE_MAGIC_CLASSIFIER_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge.
`define AMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
// Condition must never be seen at a clock edge.
`define AMC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);
`else
`define AMC_ASSERT(lbl, prop, msg)
`define AMC_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

### rtl/amc_pkg.sv
package amc_pkg;

  localparam int unsigned HEADER_BYTES = 512;
  localparam int unsigned NUM_SIGS     = 16;
  localparam int unsigned PAT_MAX      = 20;
  localparam int unsigned NUM_VOLS     = 3;
  localparam int unsigned VOL_LEN      = 5;

  localparam logic [15:0] POS_LIMIT  = 16'h9006;
  localparam logic [15:0] CK_FIRST   = 16'h0093;
  localparam logic [15:0] CK_LAST    = 16'h009a;
  localparam logic [16:0] SUM_RESET  = 17'd256;
  localparam logic [23:0] TOLERANCE  = 24'h000020;

  // Signature slots
  localparam int unsigned SIG_RAR        = 0;
  localparam int unsigned SIG_PK         = 1;
  localparam int unsigned SIG_SEVEN      = 2;
  localparam int unsigned SIG_USTAR      = 3;
  localparam int unsigned SIG_GZIP       = 4;
  localparam int unsigned SIG_BZIP       = 5;
  localparam int unsigned SIG_XZ         = 6;
  localparam int unsigned SIG_WIM        = 7;
  localparam int unsigned SIG_ZPQ_A      = 8;
  localparam int unsigned SIG_ZPQ_B      = 9;
  localparam int unsigned SIG_VETO_FIRST = 10;

  // Result classes
  localparam logic [3:0] CLASS_RAR   = 4'd0;
  localparam logic [3:0] CLASS_ZIP   = 4'd1;
  localparam logic [3:0] CLASS_SEVEN = 4'd2;
  localparam logic [3:0] CLASS_TAR   = 4'd3;
  localparam logic [3:0] CLASS_GZ    = 4'd4;
  localparam logic [3:0] CLASS_BZ2   = 4'd5;
  localparam logic [3:0] CLASS_XZ    = 4'd6;
  localparam logic [3:0] CLASS_ISO   = 4'd7;
  localparam logic [3:0] CLASS_WIM   = 4'd8;
  localparam logic [3:0] CLASS_ZPAQ  = 4'd9;
  localparam logic [3:0] CLASS_NONE  = 4'd10;

  // First offset of each signature
  localparam logic [15:0] SIG_OFF [NUM_SIGS] = '{
    16'h000, 16'h000, 16'h000, 16'h101, 16'h000, 16'h000, 16'h000, 16'h000,
    16'h000, 16'h000, 16'h01e, 16'h01e, 16'h01e, 16'h01e, 16'h01e, 16'h01e
  };

  // One past the last offset of each signature
  localparam logic [15:0] SIG_END [NUM_SIGS] = '{
    16'h006, 16'h002, 16'h006, 16'h106, 16'h003, 16'h003, 16'h005, 16'h005,
    16'h004, 16'h003, 16'h031, 16'h026, 16'h023, 16'h031, 16'h026, 16'h026
  };

  localparam logic [7:0] SIG_PAT [NUM_SIGS][PAT_MAX] = '{
    // rar
    '{8'h52, 8'h61, 8'h72, 8'h21, 8'h1a, 8'h07, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    // zip, "PK" only
    '{8'h50, 8'h4b, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    // 7z
    '{8'h37, 8'h7a, 8'hbc, 8'haf, 8'h27, 8'h1c, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    // "ustar"
    '{8'h75, 8'h73, 8'h74, 8'h61, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    // gzip
    '{8'h1f, 8'h8b, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    // "BZh"
    '{8'h42, 8'h5a, 8'h68, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    // xz
    '{8'hfd, 8'h37, 8'h7a, 8'h58, 8'h5a, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    // "MSWIM"
    '{8'h4d, 8'h53, 8'h57, 8'h49, 8'h4d, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    // "7kSt"
    '{8'h37, 8'h6b, 8'h53, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    // "zPQ"
    '{8'h7a, 8'h50, 8'h51, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    // Office part list member name
    '{8'h5b, 8'h43, 8'h6f, 8'h6e, 8'h74, 8'h65, 8'h6e, 8'h74, 8'h5f, 8'h54,
      8'h79, 8'h70, 8'h65, 8'h73, 8'h5d, 8'h2e, 8'h78, 8'h6d, 8'h6c, 8'h00},
    // "docProps"
    '{8'h64, 8'h6f, 8'h63, 8'h50, 8'h72, 8'h6f, 8'h70, 8'h73, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    // "_rels"
    '{8'h5f, 8'h72, 8'h65, 8'h6c, 8'h73, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    // "AndroidManifest.xml"
    '{8'h41, 8'h6e, 8'h64, 8'h72, 8'h6f, 8'h69, 8'h64, 8'h4d, 8'h61, 8'h6e,
      8'h69, 8'h66, 8'h65, 8'h73, 8'h74, 8'h2e, 8'h78, 8'h6d, 8'h6c, 8'h00},
    // "META-INF"
    '{8'h4d, 8'h45, 8'h54, 8'h41, 8'h2d, 8'h49, 8'h4e, 8'h46, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    // "mimetype"
    '{8'h6d, 8'h69, 8'h6d, 8'h65, 8'h74, 8'h79, 8'h70, 8'h65, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  // CD001 volume id copies
  localparam logic [15:0] VOL_OFF [NUM_VOLS] = '{16'h8001, 16'h8801, 16'h9001};
  localparam logic [15:0] VOL_END [NUM_VOLS] = '{16'h8006, 16'h8806, 16'h9006};
  localparam logic [7:0]  VOL_ID  [VOL_LEN]  = '{8'h43, 8'h44, 8'h30, 8'h30, 8'h31};

  // Per-file scan state
  typedef struct packed {
    logic [15:0] pos;
    logic [15:0] sig_miss;
    logic [2:0]  vol_miss;
    logic [16:0] hdr_sum;
    logic [23:0] octal;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    pos: 16'd0, sig_miss: 16'd0, vol_miss: 3'd0, hdr_sum: SUM_RESET, octal: 24'd0
  };

  // Step request from the input stage to the scanner
  typedef struct packed {
    logic       step;
    logic       last;
    logic [7:0] data;
  } scan_ctrl_t;

endpackage

### rtl/amc_scan.sv
`include "archive_magic_classifier_macros.svh"

module amc_scan
  import amc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  scan_ctrl_t  ctrl_i,
  output scan_state_t upd_o
);

  scan_state_t state_q, state_d, upd;
  logic [15:0] sig_rel [NUM_SIGS];
  logic [15:0] vol_rel [NUM_VOLS];
  logic [15:0] pos;
  logic [7:0]  b;

  assign pos = state_q.pos;
  assign b   = ctrl_i.data;

  // Offsets relative to each signature start
  always_comb begin
    for (int n = 0; n < NUM_SIGS; n++) begin
      sig_rel[n] = pos - SIG_OFF[n];
    end
    for (int v = 0; v < NUM_VOLS; v++) begin
      vol_rel[v] = pos - VOL_OFF[v];
    end
  end

  // State after taking the current byte
  always_comb begin
    upd = state_q;
    if (pos < POS_LIMIT) begin
      for (int n = 0; n < NUM_SIGS; n++) begin
        if (pos >= SIG_OFF[n] && pos < SIG_END[n] &&
            b != SIG_PAT[n][sig_rel[n][4:0]]) begin
          upd.sig_miss[n] = 1'b1;
        end
      end
      // tar header: checksum field is parsed, everything else summed
      if (pos < 16'(HEADER_BYTES)) begin
        if (pos >= CK_FIRST && pos <= CK_LAST) begin
          if (b >= 8'h30 && b <= 8'h37) begin
            upd.octal = {state_q.octal[20:0], b[2:0]};
          end
        end else begin
          upd.hdr_sum = state_q.hdr_sum + {9'd0, b};
        end
      end
      for (int v = 0; v < NUM_VOLS; v++) begin
        if (pos >= VOL_OFF[v] && pos < VOL_END[v] &&
            b != VOL_ID[vol_rel[v][2:0]]) begin
          upd.vol_miss[v] = 1'b1;
        end
      end
      upd.pos = pos + 16'd1;
    end
  end

  // Clear back to reset once the file's last byte is taken
  always_comb begin
    state_d = state_q;
    if (ctrl_i.step) begin
      state_d = ctrl_i.last ? SCAN_RESET : upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SCAN_RESET;
    end else begin
      state_q <= state_d;
    end
  end

  assign upd_o = upd;

  `AMC_ASSERT(a_clear_after_last, ctrl_i.step && ctrl_i.last |=> state_q.pos == 16'd0, "scan state not cleared after last byte")
  `AMC_ASSERT_NEVER(a_pos_saturates, state_q.pos > POS_LIMIT, "byte position ran past its limit")

endmodule

### rtl/amc_classify.sv
module amc_classify
  import amc_pkg::*;
(
  input  scan_state_t st_i,
  output logic [3:0]  file_class_o
);

  logic [NUM_SIGS-1:0] hit;
  logic                vol_hit;
  logic                veto;
  logic                ck_ok;
  logic [23:0]         sum_ext;

  // A signature counts once all its bytes arrived without a mismatch
  always_comb begin
    for (int n = 0; n < NUM_SIGS; n++) begin
      hit[n] = (st_i.pos >= SIG_END[n]) && !st_i.sig_miss[n];
    end
    vol_hit = 1'b0;
    for (int v = 0; v < NUM_VOLS; v++) begin
      if (st_i.pos >= VOL_END[v] && !st_i.vol_miss[v]) begin
        vol_hit = 1'b1;
      end
    end
  end

  assign veto = |hit[NUM_SIGS-1:SIG_VETO_FIRST];

  // tar checksum: exact, or off by the tolerance either way
  assign sum_ext = {7'd0, st_i.hdr_sum};
  assign ck_ok   = (st_i.pos >= 16'(HEADER_BYTES)) &&
                   (sum_ext == st_i.octal ||
                    sum_ext - TOLERANCE == st_i.octal ||
                    sum_ext + TOLERANCE == st_i.octal);

  // Priority order
  always_comb begin
    if (hit[SIG_RAR]) begin
      file_class_o = CLASS_RAR;
    end else if (hit[SIG_PK] && !veto) begin
      file_class_o = CLASS_ZIP;
    end else if (hit[SIG_SEVEN]) begin
      file_class_o = CLASS_SEVEN;
    end else if (hit[SIG_USTAR] || ck_ok) begin
      file_class_o = CLASS_TAR;
    end else if (hit[SIG_GZIP]) begin
      file_class_o = CLASS_GZ;
    end else if (hit[SIG_BZIP]) begin
      file_class_o = CLASS_BZ2;
    end else if (hit[SIG_XZ]) begin
      file_class_o = CLASS_XZ;
    end else if (vol_hit) begin
      file_class_o = CLASS_ISO;
    end else if (hit[SIG_WIM]) begin
      file_class_o = CLASS_WIM;
    end else if (hit[SIG_ZPQ_A] || hit[SIG_ZPQ_B]) begin
      file_class_o = CLASS_ZPAQ;
    end else begin
      file_class_o = CLASS_NONE;
    end
  end

endmodule

### rtl/archive_magic_classifier.sv
// Channel | Direction | Handshake              | Payload
// in      | to block  | in_valid_i / in_stall_o   | data_byte_i, last_byte_i
// out     | from block| out_valid_o / out_stall_i | file_class_o, is_archive_o
//
// One byte is taken per cycle while in_stall_o is low; bytes that are not last never wait on the output.
// A result becomes valid once its last byte has moved from the input register
// through scan/classify into the result register.
// Reset clears both valids and the scan state; no clearing pass is needed.
// in_stall_o rises only while a last byte waits in the input register behind
// an untaken result held by out_stall_i.
`include "archive_magic_classifier_macros.svh"

module archive_magic_classifier
  import amc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] file_class_o,
  output logic       is_archive_o
);

  logic        in_valid_q, in_valid_d;
  logic [7:0]  in_data_q;
  logic        in_last_q;
  logic        out_valid_q, out_valid_d;
  logic [3:0]  out_class_q;
  logic        in_accept;
  logic        out_free;
  logic        advance;
  scan_ctrl_t  ctrl;
  scan_state_t upd;
  logic [3:0]  class_d;

  // Handshake: a last byte needs a free result slot to move on
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && (!in_last_q || out_free);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_accept || (in_valid_q && !advance);
  assign out_valid_d = (advance && in_last_q) || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input item register
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_data_q <= data_byte_i;
      in_last_q <= last_byte_i;
    end
  end

  assign ctrl = '{step: advance, last: in_last_q, data: in_data_q};

  amc_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .upd_o  (upd)
  );

  amc_classify u_classify (
    .st_i         (upd),
    .file_class_o (class_d)
  );

  // Result register
  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      out_class_q <= class_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign file_class_o = out_class_q;
  assign is_archive_o = out_class_q != CLASS_NONE;

  `AMC_ASSERT(a_last_makes_result, advance && in_last_q |=> out_valid_q, "last byte advanced without a result")
  `AMC_ASSERT(a_stall_cause, in_stall_o |-> in_last_q && out_valid_q && out_stall_i, "input stalled without a blocked result")
  `AMC_ASSERT_NEVER(a_class_range, out_valid_q && out_class_q > CLASS_NONE, "result class out of range")

endmodule

### test/archive_magic_classifier_checker.sv
// Watches both channels of the classifier, predicts the class of every file
// from its accepted bytes and compares each result against the oldest one.
module archive_magic_classifier_checker
  import amc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [3:0]  file_class_i,
  input  logic        is_archive_i,
  output int unsigned mismatches_o,
  output int unsigned outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Scan limits and tar header layout
  localparam int unsigned SCAN_LIMIT  = 'h9006;
  localparam int unsigned FIELD_FIRST = 'h93;
  localparam int unsigned FIELD_LAST  = 'h9a;
  localparam int unsigned HDR_START   = 256;
  localparam int unsigned SLACK       = 'h20;

  // CD001 volume id copies
  localparam int unsigned CD_BASE   = 'h8001;
  localparam int unsigned CD_STRIDE = 'h800;
  localparam int unsigned CD_LEN    = 5;
  localparam logic [39:0] CD_TEXT   = "CD001";

  // Magic strings, right-aligned: first byte is the most significant one
  localparam int unsigned MAGIC_OFF [NUM_SIGS] = '{
    'h000, 'h000, 'h000, 'h101, 'h000, 'h000, 'h000, 'h000,
    'h000, 'h000, 'h01e, 'h01e, 'h01e, 'h01e, 'h01e, 'h01e
  };
  localparam int unsigned MAGIC_LEN [NUM_SIGS] = '{
    6, 2, 6, 5, 3, 3, 5, 5, 4, 3, 19, 8, 5, 19, 8, 8
  };
  localparam logic [151:0] MAGIC_TEXT [NUM_SIGS] = '{
    152'h52_61_72_21_1a_07,
    152'h50_4b,
    152'h37_7a_bc_af_27_1c,
    152'("ustar"),
    152'h1f_8b_08,
    152'("BZh"),
    152'hfd_37_7a_58_5a,
    152'("MSWIM"),
    152'("7kSt"),
    152'("zPQ"),
    // Office part list member name
    152'h5b_43_6f_6e_74_65_6e_74_5f_54_79_70_65_73_5d_2e_78_6d_6c,
    152'("docProps"),
    152'("_rels"),
    152'("AndroidManifest.xml"),
    152'("META-INF"),
    152'("mimetype")
  };

  typedef struct packed {
    logic [3:0] file_class;
    logic       is_archive;
  } class_result_t;

  class_result_t expected_classes [$];
  int unsigned   mismatches = 0;
  int unsigned   outstanding = 0;

  // Predicted scan state of the file in progress
  logic [15:0] scan_pos;
  logic [15:0] magic_miss;
  logic [2:0]  cd_miss;
  logic [16:0] hdr_total;
  logic [23:0] field_octal;

  assign mismatches_o  = mismatches;
  assign outstanding_o = outstanding;

  function automatic logic [7:0] magic_byte(input int unsigned n, input int unsigned k);
    return MAGIC_TEXT[n][(MAGIC_LEN[n] - 1 - k) * 8 +: 8];
  endfunction

  // A string counts only when all of its bytes arrived and none missed
  function automatic logic magic_seen(input int unsigned n);
    return (scan_pos >= MAGIC_OFF[n] + MAGIC_LEN[n]) && !magic_miss[n];
  endfunction

  task automatic clear_scan();
    scan_pos    = '0;
    magic_miss  = '0;
    cd_miss     = '0;
    hdr_total   = 17'(HDR_START);
    field_octal = '0;
  endtask

  // Fold one accepted byte into the predicted state
  task automatic scan_byte(input logic [7:0] b);
    int unsigned p;
    int unsigned n;
    int unsigned base;
    p = scan_pos;
    if (p < SCAN_LIMIT) begin
      for (n = 0; n < NUM_SIGS; n++) begin
        if (p >= MAGIC_OFF[n] && p < MAGIC_OFF[n] + MAGIC_LEN[n] &&
            b != magic_byte(n, p - MAGIC_OFF[n])) begin
          magic_miss[n] = 1'b1;
        end
      end
      // checksum field digits are parsed, everything else is summed
      if (p < HEADER_BYTES) begin
        if (p >= FIELD_FIRST && p <= FIELD_LAST) begin
          if (b >= "0" && b <= "7") begin
            field_octal = {field_octal[20:0], b[2:0]};
          end
        end else begin
          hdr_total = hdr_total + b;
        end
      end
      for (n = 0; n < 3; n++) begin
        base = CD_BASE + n * CD_STRIDE;
        if (p >= base && p < base + CD_LEN &&
            b != CD_TEXT[(CD_LEN - 1 - (p - base)) * 8 +: 8]) begin
          cd_miss[n] = 1'b1;
        end
      end
      scan_pos = 16'(p + 1);
    end
  endtask

  // Pick the class of the finished file by priority
  function automatic logic [3:0] classify_scan();
    logic        vetoed;
    logic        sum_ok;
    logic        cd_ok;
    int unsigned total;
    int unsigned stored;
    int unsigned n;
    vetoed = 1'b0;
    for (n = SIG_VETO_FIRST; n < NUM_SIGS; n++) begin
      if (magic_seen(n)) vetoed = 1'b1;
    end
    total  = hdr_total;
    stored = field_octal;
    sum_ok = (scan_pos >= HEADER_BYTES) &&
             (total == stored || total - SLACK == stored || total + SLACK == stored);
    cd_ok = 1'b0;
    for (n = 0; n < 3; n++) begin
      if (scan_pos >= CD_BASE + n * CD_STRIDE + CD_LEN && !cd_miss[n]) cd_ok = 1'b1;
    end
    if (magic_seen(SIG_RAR)) return CLASS_RAR;
    if (magic_seen(SIG_PK) && !vetoed) return CLASS_ZIP;
    if (magic_seen(SIG_SEVEN)) return CLASS_SEVEN;
    if (magic_seen(SIG_USTAR) || sum_ok) return CLASS_TAR;
    if (magic_seen(SIG_GZIP)) return CLASS_GZ;
    if (magic_seen(SIG_BZIP)) return CLASS_BZ2;
    if (magic_seen(SIG_XZ)) return CLASS_XZ;
    if (cd_ok) return CLASS_ISO;
    if (magic_seen(SIG_WIM)) return CLASS_WIM;
    if (magic_seen(SIG_ZPQ_A) || magic_seen(SIG_ZPQ_B)) return CLASS_ZPAQ;
    return CLASS_NONE;
  endfunction

  // Results are checked before this edge's input item is folded in
  always @(posedge clk_i or negedge rst_ni) begin
    class_result_t want;
    if (!rst_ni) begin
      clear_scan();
      expected_classes.delete();
      outstanding = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_classes.size() == 0) begin
          $error("file_class %0d arrived with no file pending", file_class_i);
          mismatches++;
        end else begin
          want = expected_classes.pop_front();
          if (file_class_i !== want.file_class) begin
            $error("file_class: expected %0d, actual %0d", want.file_class, file_class_i);
            mismatches++;
          end
          if (is_archive_i !== want.is_archive) begin
            $error("is_archive: expected %0d, actual %0d", want.is_archive, is_archive_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        scan_byte(data_byte_i);
        if (last_byte_i) begin
          want.file_class = classify_scan();
          want.is_archive = (want.file_class < CLASS_NONE);
          expected_classes.push_back(want);
          clear_scan();
        end
      end
      outstanding = expected_classes.size();
    end
  end

endmodule

### test/archive_magic_classifier_test.sv
// Builds files with planted signatures and streams them into the classifier.
module archive_magic_classifier_test
  import amc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES = 8;
  // "_rels", the shortest member name at the veto offset
  localparam int unsigned SHORT_VETO = SIG_VETO_FIRST + 2;

  typedef enum logic [1:0] {PACE_STEADY, PACE_BURSTY, PACE_SPARSE} pace_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] data_byte_i = '0;
  logic       last_byte_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [3:0] file_class_o;
  logic       is_archive_o;

  int unsigned mismatch_count;
  int unsigned outstanding;
  int unsigned quiet_cycles = 0;
  logic [7:0]  file_bytes [$];
  pace_t       pace = PACE_BURSTY;

  archive_magic_classifier dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .file_class_o(file_class_o),
    .is_archive_o(is_archive_o)
  );

  archive_magic_classifier_checker class_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .file_class_i (file_class_o),
    .is_archive_i (is_archive_o),
    .mismatches_o (mismatch_count),
    .outstanding_o(outstanding)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Mostly short idle spans, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 93) return $urandom_range(1, 3);
    return $urandom_range(12, 80);
  endfunction

  // Receiver stalls, with calm windows where it never stalls
  initial begin : stall_gen
    int unsigned hold;
    int unsigned calm;
    hold = 0;
    calm = 0;
    forever begin
      @(negedge clk_i);
      if (calm != 0) begin
        calm--;
        out_stall_i <= 1'b0;
      end else if (hold != 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if ($urandom_range(0, 63) == 0) calm = $urandom_range(100, 400);
        else hold = idle_len();
      end
    end
  end

  // Watchdog: ends the run when no item moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("archive_magic_classifier: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic fill_random(input int unsigned len);
    file_bytes.delete();
    repeat (len) file_bytes.push_back(8'($urandom));
  endtask

  // Flip one byte of a planted string so that it no longer matches
  task automatic spoil(input int unsigned first, input int unsigned count);
    int unsigned idx;
    idx = first + $urandom_range(0, count - 1);
    if (idx < file_bytes.size()) file_bytes[idx] ^= 8'($urandom_range(1, 255));
  endtask

  // Strings are cut short when the file ends inside them
  task automatic plant_sig(input int unsigned n, input bit broken);
    int unsigned k;
    for (k = 0; k < SIG_END[n] - SIG_OFF[n]; k++) begin
      if (SIG_OFF[n] + k < file_bytes.size()) file_bytes[SIG_OFF[n] + k] = SIG_PAT[n][k];
    end
    if (broken) spoil(SIG_OFF[n], SIG_END[n] - SIG_OFF[n]);
  endtask

  // Write the header sum plus delta as octal digits into the checksum
  // field, with non-octal fillers mixed in between the digits
  task automatic plant_sum(input int delta);
    int unsigned span;
    int unsigned total;
    int unsigned value;
    int unsigned digits;
    int unsigned i;
    int unsigned slot;
    logic [7:0]  filler;
    span  = (file_bytes.size() < HEADER_BYTES) ? file_bytes.size() : HEADER_BYTES;
    total = SUM_RESET;
    for (i = 0; i < span; i++) begin
      if (i < CK_FIRST || i > CK_LAST) total += file_bytes[i];
    end
    if (file_bytes.size() > CK_LAST) begin
      value  = total + delta;
      digits = $urandom_range(6, 8);
      for (slot = 0; slot < 8; slot++) begin
        if (digits == 8 - slot || (digits != 0 && $urandom_range(0, 1) == 1)) begin
          digits--;
          file_bytes[CK_FIRST + slot] = "0" + 8'((value >> (3 * digits)) & 7);
        end else begin
          case ($urandom_range(0, 2))
            0: filler = 8'h00;
            1: filler = " ";
            default: filler = 8'($urandom);
          endcase
          if (filler >= "0" && filler <= "7") filler = filler + 8'd8;
          file_bytes[CK_FIRST + slot] = filler;
        end
      end
    end
  endtask

  // Drive one item and hold it until accepted; entered at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    case (pace)
      PACE_STEADY: gap = 0;
      PACE_SPARSE: gap = ($urandom_range(0, 49) == 0) ? idle_len() : 0;
      default:     gap = idle_len();
    endcase
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic send_file();
    int unsigned i;
    for (i = 0; i < file_bytes.size(); i++) send_byte(file_bytes[i], i == file_bytes.size() - 1);
  endtask

  // Sender holds off until every predicted class has come out
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
  endtask

  task automatic run_file(input int unsigned len, input int first_sig, input int second_sig,
                          input bit with_sum, input int delta, input bit broken);
    fill_random(len);
    if (first_sig >= 0) plant_sig(first_sig, broken);
    if (second_sig >= 0) plant_sig(second_sig, 1'b0);
    if (with_sum) plant_sum(delta);
    send_file();
  endtask

  initial begin : stimulus
    int          lead_list [7];
    int unsigned f;
    int unsigned len;
    int unsigned pick;
    int unsigned first;
    lead_list = '{SIG_SEVEN, SIG_GZIP, SIG_BZIP, SIG_XZ, SIG_WIM, SIG_ZPQ_A, SIG_ZPQ_B};

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed files: one-byte file, signatures exact, cut short and broken
    pace = PACE_BURSTY;
    run_file(1, -1, -1, 1'b0, 0, 1'b0);
    run_file(SIG_END[SIG_RAR], SIG_RAR, -1, 1'b0, 0, 1'b0);
    run_file(SIG_END[SIG_RAR] - 1, SIG_RAR, -1, 1'b0, 0, 1'b0);
    run_file(SIG_END[SIG_RAR], SIG_RAR, -1, 1'b0, 0, 1'b1);
    run_file(SIG_END[SIG_PK], SIG_PK, -1, 1'b0, 0, 1'b0);
    // member name blocks zip, but not when the file ends one byte early
    run_file(SIG_END[SHORT_VETO], SIG_PK, SHORT_VETO, 1'b0, 0, 1'b0);
    run_file(SIG_END[SHORT_VETO] - 1, SIG_PK, SHORT_VETO, 1'b0, 0, 1'b0);
    foreach (lead_list[i]) run_file(SIG_END[lead_list[i]], lead_list[i], -1, 1'b0, 0, 1'b0);
    // short header never passes the checksum test
    pace = PACE_SPARSE;
    run_file(CK_LAST + 1, -1, -1, 1'b1, 0, 1'b0);
    hold_until_drained();

    // Random short files, mostly well formed
    for (f = 0; f < 10; f++) begin
      if (f % 5 == 4) hold_until_drained();
      pick = $urandom_range(0, 99);
      if (pick < 60) len = $urandom_range(1, 8);
      else len = $urandom_range(9, SIG_END[SIG_VETO_FIRST]);
      fill_random(len);
      if ($urandom_range(0, 3) != 0) begin
        first = ($urandom_range(0, 2) == 0) ? SIG_PK : $urandom_range(SIG_RAR, SIG_ZPQ_B);
        plant_sig(first, $urandom_range(0, 4) == 0);
        if (first == SIG_PK && $urandom_range(0, 1) == 1) begin
          plant_sig($urandom_range(SIG_VETO_FIRST, NUM_SIGS - 1), $urandom_range(0, 3) == 0);
        end
      end else if ($urandom_range(0, 1) == 1) begin
        plant_sig($urandom_range(0, NUM_SIGS - 1), 1'b1);
      end
      case ($urandom_range(0, 2))
        0: pace = PACE_STEADY;
        1: pace = PACE_SPARSE;
        default: pace = PACE_BURSTY;
      endcase
      send_file();
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("archive_magic_classifier: match");
    end else begin
      $display("archive_magic_classifier: mismatch");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/amc_pkg.sv
rtl/amc_scan.sv
rtl/amc_classify.sv
rtl/archive_magic_classifier.sv
test/archive_magic_classifier_checker.sv
test/archive_magic_classifier_test.sv
